// ===== sv/vector_digit_rasterizer_macros.svh =====
// Assertion macros shared by the vector digit rasterizer RTL.
`ifndef VECTOR_DIGIT_RASTERIZER_MACROS_SVH
`define VECTOR_DIGIT_RASTERIZER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VDR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/vdr_pkg.sv =====
// Package of the vector digit rasterizer: types, font tables and microcode.
package vdr_pkg;

  localparam int COORD_W = 11;
  localparam int CURSOR_W = 10;
  localparam int PTR_W = 6;
  localparam int CNT_W = 3;
  localparam int NWR_W = 6;

  localparam logic [23:0] WHITE_RGB = 24'hFFFFFF;
  localparam logic [3:0] GLYPH_MAX = 4'd10;
  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [NWR_W-1:0] MAX_RES = 6'd55;
  localparam logic signed [COORD_W-1:0] CURSOR_MAX = 11'sd511;
  localparam logic [PTR_W-1:0] DASH_FIRST = 6'd41;
  localparam logic [CNT_W-1:0] DASH_COUNT = 3'd2;
  localparam logic [4:0] DASH_ADVANCE = 5'd2;

  typedef enum logic [1:0] {
    CMD_DIGIT      = 2'd0,
    CMD_DASH       = 2'd1,
    CMD_SET_CURSOR = 2'd2,
    CMD_NOP        = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_OVERLAY = 2'd0,
    MODE_WHITE   = 2'd1,
    MODE_OFF_A   = 2'd2,
    MODE_OFF_B   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_BRIGHTNESS   = 2'd0,
    REG_GLYPH_WIDTH  = 2'd1,
    REG_GLYPH_HEIGHT = 2'd2,
    REG_ADVANCE_STEP = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] brightness;
    logic [3:0] glyph_width;
    logic [3:0] glyph_height;
    logic [4:0] advance_step;
  } cfg_t;

  typedef struct packed {
    logic [4:0] ax;
    logic [4:0] ay;
    logic [4:0] bx;
    logic [4:0] by;
  } seg_t;

  // Microprogram addresses.
  typedef enum logic [3:0] {
    U_IDLE     = 4'd0,
    U_DIGIT    = 4'd1,
    U_DASH     = 4'd2,
    U_SETC     = 4'd3,
    U_SEG_LOAD = 4'd4,
    U_SEG_PIX  = 4'd5,
    U_SEG_NEXT = 4'd6,
    U_ADVANCE  = 4'd7,
    U_FINISH   = 4'd8
  } upc_t;

  // Branch kinds of a control word.
  typedef enum logic [2:0] {
    BR_DISPATCH = 3'd0,
    BR_DIGIT    = 3'd1,
    BR_JUMP     = 3'd2,
    BR_PIX      = 3'd3,
    BR_MORE     = 3'd4,
    BR_FLUSH    = 3'd5
  } br_t;

  typedef struct packed {
    logic take;
    logic load_digit;
    logic load_dash;
    logic set_cursor;
    logic load_seg;
    logic step;
    logic next_seg;
    logic advance;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic digit_bad;
    logic mode_bad;
    logic at_end;
    logic more_segs;
  } stat_t;

  typedef struct packed {
    br_t   br;
    upc_t  target;
    ctrl_t act;
  } ucode_t;

  function automatic ucode_t ucode_rom(upc_t a);
    ucode_t w;
    w = '0;
    unique case (a)
      U_IDLE: begin
        w.br = BR_DISPATCH; w.target = U_IDLE; w.act.take = 1'b1;
      end
      U_DIGIT: begin
        w.br = BR_DIGIT; w.target = U_SEG_LOAD; w.act.load_digit = 1'b1;
      end
      U_DASH: begin
        w.br = BR_JUMP; w.target = U_SEG_LOAD; w.act.load_dash = 1'b1;
      end
      U_SETC: begin
        w.br = BR_JUMP; w.target = U_FINISH; w.act.set_cursor = 1'b1;
      end
      U_SEG_LOAD: begin
        w.br = BR_JUMP; w.target = U_SEG_PIX; w.act.load_seg = 1'b1;
      end
      U_SEG_PIX: begin
        w.br = BR_PIX; w.target = U_SEG_NEXT; w.act.step = 1'b1;
      end
      U_SEG_NEXT: begin
        w.br = BR_MORE; w.target = U_SEG_LOAD; w.act.next_seg = 1'b1;
      end
      U_ADVANCE: begin
        w.br = BR_JUMP; w.target = U_FINISH; w.act.advance = 1'b1;
      end
      U_FINISH: begin
        w.br = BR_FLUSH; w.target = U_IDLE; w.act.finish = 1'b1;
      end
      default: begin
        w.br = BR_JUMP; w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

  // Font: axis-aligned strokes on a 0..16 grid, digits first, dash last.
  function automatic seg_t seg_rom(logic [PTR_W-1:0] i);
    seg_t s;
    unique case (i)
      6'd0:  s = '{5'd0,  5'd0,  5'd16, 5'd0};
      6'd1:  s = '{5'd0,  5'd0,  5'd0,  5'd16};
      6'd2:  s = '{5'd0,  5'd16, 5'd16, 5'd16};
      6'd3:  s = '{5'd16, 5'd0,  5'd16, 5'd16};
      6'd4:  s = '{5'd8,  5'd0,  5'd8,  5'd16};
      6'd5:  s = '{5'd0,  5'd0,  5'd16, 5'd0};
      6'd6:  s = '{5'd0,  5'd16, 5'd8,  5'd16};
      6'd7:  s = '{5'd0,  5'd0,  5'd16, 5'd0};
      6'd8:  s = '{5'd0,  5'd0,  5'd0,  5'd8};
      6'd9:  s = '{5'd0,  5'd8,  5'd16, 5'd8};
      6'd10: s = '{5'd16, 5'd8,  5'd16, 5'd16};
      6'd11: s = '{5'd0,  5'd16, 5'd16, 5'd16};
      6'd12: s = '{5'd0,  5'd0,  5'd16, 5'd0};
      6'd13: s = '{5'd0,  5'd8,  5'd16, 5'd8};
      6'd14: s = '{5'd0,  5'd16, 5'd16, 5'd16};
      6'd15: s = '{5'd16, 5'd0,  5'd16, 5'd16};
      6'd16: s = '{5'd16, 5'd0,  5'd16, 5'd16};
      6'd17: s = '{5'd0,  5'd8,  5'd0,  5'd16};
      6'd18: s = '{5'd0,  5'd8,  5'd16, 5'd8};
      6'd19: s = '{5'd0,  5'd0,  5'd16, 5'd0};
      6'd20: s = '{5'd16, 5'd0,  5'd16, 5'd8};
      6'd21: s = '{5'd0,  5'd8,  5'd16, 5'd8};
      6'd22: s = '{5'd0,  5'd8,  5'd0,  5'd16};
      6'd23: s = '{5'd0,  5'd16, 5'd16, 5'd16};
      6'd24: s = '{5'd0,  5'd0,  5'd16, 5'd0};
      6'd25: s = '{5'd0,  5'd0,  5'd0,  5'd16};
      6'd26: s = '{5'd0,  5'd8,  5'd16, 5'd8};
      6'd27: s = '{5'd0,  5'd16, 5'd16, 5'd16};
      6'd28: s = '{5'd16, 5'd0,  5'd16, 5'd8};
      6'd29: s = '{5'd0,  5'd16, 5'd16, 5'd16};
      6'd30: s = '{5'd16, 5'd0,  5'd16, 5'd16};
      6'd31: s = '{5'd0,  5'd0,  5'd16, 5'd0};
      6'd32: s = '{5'd0,  5'd8,  5'd16, 5'd8};
      6'd33: s = '{5'd0,  5'd16, 5'd16, 5'd16};
      6'd34: s = '{5'd0,  5'd0,  5'd0,  5'd16};
      6'd35: s = '{5'd16, 5'd0,  5'd16, 5'd16};
      6'd36: s = '{5'd0,  5'd16, 5'd16, 5'd16};
      6'd37: s = '{5'd0,  5'd8,  5'd0,  5'd16};
      6'd38: s = '{5'd0,  5'd8,  5'd16, 5'd8};
      6'd39: s = '{5'd16, 5'd0,  5'd16, 5'd16};
      6'd40: s = '{5'd0,  5'd0,  5'd16, 5'd0};
      6'd41: s = '{5'd0,  5'd4,  5'd0,  5'd5};
      6'd42: s = '{5'd0,  5'd12, 5'd0,  5'd13};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [PTR_W-1:0] seg_first(logic [3:0] d);
    logic [PTR_W-1:0] f;
    unique case (d)
      4'd0: f = 6'd0;
      4'd1: f = 6'd4;
      4'd2: f = 6'd7;
      4'd3: f = 6'd12;
      4'd4: f = 6'd16;
      4'd5: f = 6'd19;
      4'd6: f = 6'd24;
      4'd7: f = 6'd29;
      4'd8: f = 6'd31;
      4'd9: f = 6'd36;
      default: f = 6'd0;
    endcase
    return f;
  endfunction

  function automatic logic [CNT_W-1:0] seg_count(logic [3:0] d);
    logic [CNT_W-1:0] c;
    unique case (d)
      4'd0: c = 3'd4;
      4'd1: c = 3'd3;
      4'd2: c = 3'd5;
      4'd3: c = 3'd4;
      4'd4: c = 3'd3;
      4'd5: c = 3'd5;
      4'd6: c = 3'd5;
      4'd7: c = 3'd2;
      4'd8: c = 3'd5;
      4'd9: c = 3'd5;
      default: c = 3'd0;
    endcase
    return c;
  endfunction

  // (coord * size) >> 4; at most 16 * 10, so the result fits four bits.
  function automatic logic [3:0] scale_coord(logic [4:0] c, logic [3:0] size);
    logic [8:0] p;
    p = 9'(c) * 9'(size);
    return p[7:4];
  endfunction

  // Even size, saturated at the largest glyph.
  function automatic logic [3:0] glyph_size(logic [3:0] v);
    logic [3:0] s;
    s = {v[3:1], 1'b0};
    return (s > GLYPH_MAX) ? GLYPH_MAX : s;
  endfunction

endpackage

// ===== sv/vdr_cfg_regs.sv =====
// Configuration register bank of the vector digit rasterizer with its APB port.
module vdr_cfg_regs import vdr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[3:2]);
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness   <= 8'd255;
      cfg.glyph_width  <= 4'd6;
      cfg.glyph_height <= 4'd10;
      cfg.advance_step <= 5'd8;
    end else if (wr) begin
      unique case (idx)
        REG_BRIGHTNESS:   cfg.brightness   <= pwdata[7:0];
        REG_GLYPH_WIDTH:  cfg.glyph_width  <= glyph_size(pwdata[3:0]);
        REG_GLYPH_HEIGHT: cfg.glyph_height <= glyph_size(pwdata[3:0]);
        REG_ADVANCE_STEP: cfg.advance_step <= pwdata[4:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BRIGHTNESS:   prdata = {24'd0, cfg.brightness};
      REG_GLYPH_WIDTH:  prdata = {28'd0, cfg.glyph_width};
      REG_GLYPH_HEIGHT: prdata = {28'd0, cfg.glyph_height};
      REG_ADVANCE_STEP: prdata = {27'd0, cfg.advance_step};
    endcase
  end

endmodule

// ===== sv/vdr_sequencer.sv =====
// Microprogram sequencer: step counter, control word table and branch logic.
module vdr_sequencer import vdr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] cmd,
  input  stat_t      stat,
  input  logic       pix_ok,
  input  logic       fin_ok,
  output ctrl_t      ctrl,
  output logic       idle
);

  upc_t   upc;
  upc_t   upc_next;
  ucode_t uw;

  assign uw = ucode_rom(upc);
  assign idle = (upc == U_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  always_comb begin
    ctrl = uw.act;
    ctrl.take = uw.act.take & in_valid;
    ctrl.step = uw.act.step & pix_ok;
    ctrl.finish = uw.act.finish & fin_ok;
    upc_next = upc;
    unique case (uw.br)
      BR_DISPATCH: begin
        if (in_valid) begin
          unique case (cmd_t'(cmd))
            CMD_DIGIT:      upc_next = U_DIGIT;
            CMD_DASH:       upc_next = U_DASH;
            CMD_SET_CURSOR: upc_next = U_SETC;
            CMD_NOP:        upc_next = U_FINISH;
          endcase
        end
      end
      BR_DIGIT: begin
        priority if (stat.digit_bad) begin
          upc_next = U_FINISH;
        end else if (stat.mode_bad) begin
          upc_next = U_ADVANCE;
        end else begin
          upc_next = uw.target;
        end
      end
      BR_JUMP: upc_next = uw.target;
      BR_PIX: begin
        if (pix_ok && stat.at_end) begin
          upc_next = uw.target;
        end
      end
      BR_MORE: upc_next = stat.more_segs ? uw.target : U_ADVANCE;
      BR_FLUSH: begin
        if (fin_ok) begin
          upc_next = uw.target;
        end
      end
      default: upc_next = U_IDLE;
    endcase
  end

endmodule

// ===== sv/vdr_datapath.sv =====
// Datapath: input latch, cursor, stroke endpoints and the pixel stepper.
module vdr_datapath import vdr_pkg::*; #(
  parameter int MATRIX_WIDTH = 32,
  parameter int MATRIX_HEIGHT = 16,
  localparam int XW = (MATRIX_WIDTH > 1) ? $clog2(MATRIX_WIDTH) : 1,
  localparam int YW = (MATRIX_HEIGHT > 1) ? $clog2(MATRIX_HEIGHT) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  ctrl_t               ctrl,
  input  cfg_t                cfg,
  input  logic [3:0]          digit,
  input  logic [23:0]         digit_color,
  input  logic [1:0]          draw_mode,
  input  logic signed [9:0]   new_cursor_x,
  input  logic signed [9:0]   new_cursor_y,
  output stat_t               stat,
  output logic                pix_push,
  output logic [XW-1:0]       pix_x,
  output logic [YW-1:0]       pix_y,
  output logic [31:0]         pix_value
);

  localparam logic signed [COORD_W-1:0] X_LIM = COORD_W'(MATRIX_WIDTH);
  localparam logic signed [COORD_W-1:0] Y_LIM = COORD_W'(MATRIX_HEIGHT);

  logic [3:0]                 digit_q;
  logic [23:0]                color_q;
  mode_t                      mode_q;
  logic signed [CURSOR_W-1:0] ncx_q;
  logic signed [CURSOR_W-1:0] ncy_q;
  logic signed [CURSOR_W-1:0] cursor_x;
  logic signed [CURSOR_W-1:0] cursor_y;
  logic [PTR_W-1:0]           seg_ptr;
  logic [CNT_W-1:0]           seg_cnt;
  logic [4:0]                 adv_amt;
  logic [NWR_W-1:0]           nwr;
  logic signed [COORD_W-1:0]  cx;
  logic signed [COORD_W-1:0]  cy;
  logic signed [COORD_W-1:0]  ex;
  logic signed [COORD_W-1:0]  ey;

  seg_t                       s;
  logic signed [COORD_W-1:0]  curx_ext;
  logic signed [COORD_W-1:0]  cury_ext;
  logic signed [COORD_W-1:0]  sx0;
  logic signed [COORD_W-1:0]  sy0;
  logic signed [COORD_W-1:0]  sx1;
  logic signed [COORD_W-1:0]  sy1;
  logic signed [COORD_W-1:0]  adv_sum;
  logic                       on_matrix;

  assign s = seg_rom(seg_ptr);
  assign curx_ext = {cursor_x[CURSOR_W-1], cursor_x};
  assign cury_ext = {cursor_y[CURSOR_W-1], cursor_y};
  assign sx0 = curx_ext + $signed({7'd0, scale_coord(s.ax, cfg.glyph_width)});
  assign sy0 = cury_ext + $signed({7'd0, scale_coord(s.ay, cfg.glyph_height)});
  assign sx1 = curx_ext + $signed({7'd0, scale_coord(s.bx, cfg.glyph_width)});
  assign sy1 = cury_ext + $signed({7'd0, scale_coord(s.by, cfg.glyph_height)});
  assign adv_sum = curx_ext + $signed({6'd0, adv_amt});

  assign on_matrix = !cx[COORD_W-1] && !cy[COORD_W-1] && (cx < X_LIM) && (cy < Y_LIM);

  assign stat.digit_bad = (digit_q > DIGIT_MAX);
  assign stat.mode_bad = (mode_q != MODE_OVERLAY) && (mode_q != MODE_WHITE);
  assign stat.at_end = (cx == ex) && (cy == ey);
  assign stat.more_segs = (seg_cnt > 3'd1);

  assign pix_push = ctrl.step && on_matrix && (nwr < MAX_RES);
  assign pix_x = cx[XW-1:0];
  assign pix_y = cy[YW-1:0];

  // Input fields are payload and are simply captured on acceptance.
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      digit_q <= digit;
      color_q <= digit_color;
      mode_q <= mode_t'(draw_mode);
      ncx_q <= new_cursor_x;
      ncy_q <= new_cursor_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      nwr <= '0;
      seg_ptr <= '0;
      seg_cnt <= '0;
    end else begin
      if (ctrl.take) begin
        nwr <= '0;
      end else if (pix_push) begin
        nwr <= nwr + 6'd1;
      end
      if (ctrl.load_digit) begin
        seg_ptr <= seg_first(digit_q);
        seg_cnt <= seg_count(digit_q);
      end else if (ctrl.load_dash) begin
        seg_ptr <= DASH_FIRST;
        seg_cnt <= DASH_COUNT;
      end else if (ctrl.next_seg) begin
        seg_ptr <= seg_ptr + 6'd1;
        seg_cnt <= seg_cnt - 3'd1;
      end
      if (ctrl.set_cursor) begin
        cursor_x <= ncx_q;
        cursor_y <= ncy_q;
      end else if (ctrl.advance) begin
        cursor_x <= (adv_sum > CURSOR_MAX) ? CURSOR_MAX[CURSOR_W-1:0]
                                           : adv_sum[CURSOR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_digit) begin
      pix_value <= {cfg.brightness, (mode_q == MODE_WHITE) ? WHITE_RGB : color_q};
      adv_amt <= cfg.advance_step;
    end else if (ctrl.load_dash) begin
      pix_value <= {cfg.brightness, WHITE_RGB};
      adv_amt <= DASH_ADVANCE;
    end
  end

  // Strokes are axis-aligned, so the walk moves one unit along the
  // coordinate that still differs from the end point.
  always_ff @(posedge clk) begin
    if (ctrl.load_seg) begin
      cx <= sx0;
      cy <= sy0;
      ex <= sx1;
      ey <= sy1;
    end else if (ctrl.step) begin
      if (cx != ex) begin
        cx <= (ex > cx) ? cx + 11'sd1 : cx - 11'sd1;
      end else if (cy != ey) begin
        cy <= (ey > cy) ? cy + 11'sd1 : cy - 11'sd1;
      end
    end
  end

endmodule

// ===== sv/vector_digit_rasterizer.sv =====
// Top level of the vector digit rasterizer: sequencer, datapath and output stage.
//
// Usage. One input transaction on (in_valid, in_stall) carries a command:
// draw a digit, draw a dash, set the cursor, or no operation. Each command
// yields one or more output transactions on (out_valid, out_stall): one per
// stroke pixel that lands on the matrix, at most 55, or a single transaction with
// write_enable low when nothing is drawn. The last transaction of a command
// has last set. Configuration must be written via the APB port while idle;
// the block itself does not enforce this. A command is processed by a
// microcoded sequencer that handles one control step per cycle while the
// receiver is not stalling: each stroke is loaded, walked one stroke pixel
// per cycle and followed by a next-stroke step, and a cursor advance and
// the closing step end a glyph.
// in_stall is high from acceptance until the final transaction has been
// handed to the output register. Reset clears the cursor to the origin,
// loads the register defaults and empties the output stage.
// When the receiver stalls, a held pixel and the output register stay put,
// and the sequencer waits at a pixel step with a pixel held, or at finish.
`include "vector_digit_rasterizer_macros.svh"
module vector_digit_rasterizer import vdr_pkg::*; #(
  parameter int MATRIX_WIDTH = 32,
  parameter int MATRIX_HEIGHT = 16,
  localparam int XW = (MATRIX_WIDTH > 1) ? $clog2(MATRIX_WIDTH) : 1,
  localparam int YW = (MATRIX_HEIGHT > 1) ? $clog2(MATRIX_HEIGHT) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [3:0]        digit,
  input  logic [23:0]       digit_color,
  input  logic [1:0]        draw_mode,
  input  logic signed [9:0] new_cursor_x,
  input  logic signed [9:0] new_cursor_y,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              write_enable,
  output logic [XW-1:0]     pixel_x,
  output logic [YW-1:0]     pixel_y,
  output logic [31:0]       pixel_value,
  output logic              last
);

  cfg_t          cfg;
  ctrl_t         ctrl;
  stat_t         stat;
  logic          idle;
  logic          pix_push;
  logic [XW-1:0] pix_x;
  logic [YW-1:0] pix_y;
  logic [31:0]   pix_value;

  // The most recent pixel is held back one step, so that the final pixel
  // of a command can still be marked as last once the walk has ended.
  logic          pend_valid;
  logic          pend_valid_next;
  logic [XW-1:0] pend_x;
  logic [YW-1:0] pend_y;
  logic [31:0]   pend_value;
  logic          out_valid_next;
  logic          out_free;
  logic          out_load;
  logic          pix_ok;
  logic          fin_ok;

  vdr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vdr_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .stat     (stat),
    .pix_ok   (pix_ok),
    .fin_ok   (fin_ok),
    .ctrl     (ctrl),
    .idle     (idle)
  );

  vdr_datapath #(
    .MATRIX_WIDTH  (MATRIX_WIDTH),
    .MATRIX_HEIGHT (MATRIX_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .cfg          (cfg),
    .digit        (digit),
    .digit_color  (digit_color),
    .draw_mode    (draw_mode),
    .new_cursor_x (new_cursor_x),
    .new_cursor_y (new_cursor_y),
    .stat         (stat),
    .pix_push     (pix_push),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .pix_value    (pix_value)
  );

  assign in_stall = !idle;

  // A new pixel pushes the held one into the output register, so it needs
  // room there only when a pixel is already held. The closing step always
  // writes the output register.
  assign out_free = !out_valid || !out_stall;
  assign pix_ok = !pend_valid || out_free;
  assign fin_ok = out_free;
  assign out_load = ctrl.finish || (pix_push && pend_valid);

  always_comb begin
    out_valid_next = out_load ? 1'b1 : (out_valid && out_stall);
    pend_valid_next = pend_valid;
    if (ctrl.finish) begin
      pend_valid_next = 1'b0;
    end else if (pix_push) begin
      pend_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_push) begin
      pend_x <= pix_x;
      pend_y <= pix_y;
      pend_value <= pix_value;
    end
    if (out_load) begin
      write_enable <= pend_valid;
      pixel_x <= pend_valid ? pend_x : '0;
      pixel_y <= pend_valid ? pend_y : '0;
      pixel_value <= pend_valid ? pend_value : 32'd0;
      last <= ctrl.finish;
    end
  end

  `VDR_ASSERT_IMP(a_idle_no_pending, !in_stall, !pend_valid, "pixel held while idle")
  `VDR_ASSERT_NEXT(a_finish_gives_last, ctrl.finish, out_valid && last, "close without last")
  `VDR_ASSERT_IMP(a_push_has_room, pix_push && pend_valid, out_free, "output overrun")
  `VDR_ASSERT_IMP(a_empty_is_last, out_valid && !write_enable, last, "empty result not last")

endmodule
